// ===== src/rkh_pkg.sv =====
// ----------------------------------------------------------------------------
// rkh_pkg
// Shared codes and controller/datapath interface structs for the
// rectangle-keyed chained hash table.
// ----------------------------------------------------------------------------
package rkh_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_LOOKUP = 2'd1;
    localparam logic [1:0] ACT_REKEY  = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_MISS = 2'd3;

    localparam logic [2:0] OUT_OK   = 3'd0;
    localparam logic [2:0] OUT_DUP  = 3'd1;
    localparam logic [2:0] OUT_FULL = 3'd2;
    localparam logic [2:0] OUT_MISS = 3'd3;
    localparam logic [2:0] OUT_HIT  = 3'd4;

    typedef struct packed {
        logic       latch;
        logic       hash_start;
        logic       hash_sel;
        logic       clr_wr;
        logic       head_rd;
        logic       load_cur;
        logic       node_rd;
        logic       step;
        logic       unlink;
        logic       relink;
        logic       ins;
        logic       load_out;
        logic [2:0] out_sel;
    } cmd_t;

    typedef struct packed {
        logic       hash_done;
        logic       cur_end;
        logic       match;
        logic       full;
        logic       clr_last;
        logic [1:0] action;
    } sts_t;

endpackage

// ===== src/rkh_hash.sv =====
// ----------------------------------------------------------------------------
// rkh_hash
// Key hash and reduction modulo the bucket count by reciprocal multiply:
// key capture, quotient estimate, remainder, final compare and subtract.
// ----------------------------------------------------------------------------
module rkh_hash
    import rkh_pkg::*;
#(
    parameter int BUCKETS = 7561
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [15:0]                tex_id,
    input  logic signed [15:0]         x_min,
    input  logic signed [15:0]         x_max,
    input  logic signed [15:0]         y_min,
    input  logic signed [15:0]         y_max,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] bucket
);

    localparam int BW = $clog2(BUCKETS);
    // floor(2^32 / BUCKETS); quotient estimate is low by at most one
    localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));
    localparam logic [31:0] BK    = 32'(BUCKETS);

    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic signed [16:0] sx_adj;
    logic signed [16:0] sy_adj;
    logic [15:0]        cx;
    logic [15:0]        cy;
    logic [31:0]        cy97;
    logic [31:0]        tex101;
    logic [31:0]        h;
    logic [63:0]        prod;
    logic [31:0]        qb;
    logic [31:0]        r_sub;

    logic [31:0]   h_reg;
    logic [31:0]   h1_reg;
    logic [31:0]   q_reg;
    logic [31:0]   r_reg;
    logic [BW-1:0] bucket_reg;
    logic          v1_reg;
    logic          v2_reg;
    logic          v3_reg;
    logic          done_reg;

    always_comb
    begin
        sx     = 17'(x_min) + 17'(x_max);
        sy     = 17'(y_min) + 17'(y_max);
        sx_adj = sx + {16'd0, sx[16]};
        sy_adj = sy + {16'd0, sy[16]};
        cx     = sx_adj[16:1];
        cy     = sy_adj[16:1];
        cy97   = 32'($signed({{16{cy[15]}}, cy}) * 32'sd97);
        tex101 = 32'({16'd0, tex_id} * 32'd101);
        h      = {{16{cx[15]}}, cx} ^ cy97 ^ tex101;
        prod   = 64'(h_reg) * 64'(RECIP);
        qb     = q_reg * BK;
        r_sub  = r_reg - BK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            h_reg <= h;
        if (v1_reg)
        begin
            q_reg  <= prod[63:32];
            h1_reg <= h_reg;
        end
        if (v2_reg)
            r_reg <= h1_reg - qb;
        if (v3_reg)
            bucket_reg <= (r_reg >= BK) ? r_sub[BW-1:0] : r_reg[BW-1:0];
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

// ===== src/rkh_datapath.sv =====
// ----------------------------------------------------------------------------
// rkh_datapath
// Key registers, bucket head and node memories, chain pointers, result regs.
// ----------------------------------------------------------------------------
module rkh_datapath
    import rkh_pkg::*;
#(
    parameter int BUCKETS    = 7561,
    parameter int POOL_NODES = 8192
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [1:0]         action,
    input  logic [15:0]        tex_id,
    input  logic signed [15:0] x_min,
    input  logic signed [15:0] x_max,
    input  logic signed [15:0] y_min,
    input  logic signed [15:0] y_max,
    input  logic [15:0]        new_tex_id,
    input  logic signed [15:0] new_x_min,
    input  logic signed [15:0] new_x_max,
    input  logic signed [15:0] new_y_min,
    input  logic signed [15:0] new_y_max,
    input  logic [31:0]        entry_value,
    output logic               hit,
    output logic [31:0]        stored_value,
    output logic [1:0]         status
);

    localparam int BW = $clog2(BUCKETS);
    localparam int IW = $clog2(POOL_NODES);
    localparam int PW = $clog2(POOL_NODES + 1);

    logic [1:0]  action_reg;
    logic [15:0] tex_reg;
    logic [63:0] rect_reg;
    logic [15:0] ntex_reg;
    logic [63:0] nrect_reg;
    logic [31:0] val_reg;

    logic [PW-1:0] cur_reg;
    logic [PW-1:0] prev_reg;
    logic [PW-1:0] hb_reg;
    logic [PW-1:0] used_reg;
    logic [BW-1:0] clr_reg;

    logic          hit_reg;
    logic [31:0]   value_reg;
    logic [1:0]    status_reg;

    logic [PW-1:0]  head_mem [BUCKETS];
    logic [111:0]   node_mem [POOL_NODES];
    logic [PW-1:0]  link_mem [POOL_NODES];
    logic [PW-1:0]  head_rd_reg;
    logic [111:0]   node_rd_reg;
    logic [PW-1:0]  link_rd_reg;

    logic          h_done;
    logic [BW-1:0] bucket;

    logic          head_we;
    logic [BW-1:0] head_wa;
    logic [PW-1:0] head_wd;
    logic          link_we;
    logic [IW-1:0] link_wa;
    logic [PW-1:0] link_wd;
    logic          node_we;
    logic [IW-1:0] node_wa;
    logic [111:0]  node_wd;

    logic [PW-1:0] cur_m1;
    logic [PW-1:0] prev_m1;
    logic [IW-1:0] cur_idx;
    logic [IW-1:0] prev_idx;
    logic [IW-1:0] used_idx;

    rkh_hash #(
        .BUCKETS (BUCKETS)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.hash_start),
        .tex_id (cmd.hash_sel ? ntex_reg : tex_reg),
        .x_min  (cmd.hash_sel ? nrect_reg[15:0]  : rect_reg[15:0]),
        .x_max  (cmd.hash_sel ? nrect_reg[31:16] : rect_reg[31:16]),
        .y_min  (cmd.hash_sel ? nrect_reg[47:32] : rect_reg[47:32]),
        .y_max  (cmd.hash_sel ? nrect_reg[63:48] : rect_reg[63:48]),
        .done   (h_done),
        .bucket (bucket)
    );

    always_comb
    begin
        cur_m1   = cur_reg - PW'(1);
        prev_m1  = prev_reg - PW'(1);
        cur_idx  = cur_m1[IW-1:0];
        prev_idx = prev_m1[IW-1:0];
        used_idx = used_reg[IW-1:0];

        head_we = 1'b0;
        head_wa = bucket;
        head_wd = '0;
        link_we = 1'b0;
        link_wa = cur_idx;
        link_wd = head_rd_reg;
        node_we = 1'b0;
        node_wa = cur_idx;
        node_wd = {ntex_reg, nrect_reg, node_rd_reg[31:0]};

        if (cmd.clr_wr)
        begin
            head_we = 1'b1;
            head_wa = clr_reg;
        end
        else if (cmd.unlink)
        begin
            if (prev_reg == '0)
            begin
                head_we = 1'b1;
                head_wd = link_rd_reg;
            end
            else
            begin
                link_we = 1'b1;
                link_wa = prev_idx;
                link_wd = link_rd_reg;
            end
        end
        else if (cmd.relink)
        begin
            head_we = 1'b1;
            head_wd = cur_reg;
            link_we = 1'b1;
            node_we = 1'b1;
        end
        else if (cmd.ins)
        begin
            head_we = 1'b1;
            head_wd = used_reg + PW'(1);
            link_we = 1'b1;
            link_wa = used_idx;
            link_wd = hb_reg;
            node_we = 1'b1;
            node_wa = used_idx;
            node_wd = {tex_reg, rect_reg, val_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        if (cmd.head_rd)
            head_rd_reg <= head_mem[bucket];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[node_wa] <= node_wd;
        if (cmd.node_rd)
            node_rd_reg <= node_mem[cur_idx];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[link_wa] <= link_wd;
        if (cmd.node_rd)
            link_rd_reg <= link_mem[cur_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (cmd.clr_wr)
                clr_reg <= clr_reg + BW'(1);
            if (cmd.ins)
                used_reg <= used_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            action_reg <= action;
            tex_reg    <= tex_id;
            rect_reg   <= {y_max, y_min, x_max, x_min};
            ntex_reg   <= new_tex_id;
            nrect_reg  <= {new_y_max, new_y_min, new_x_max, new_x_min};
            val_reg    <= entry_value;
        end
        if (cmd.load_cur)
        begin
            cur_reg  <= head_rd_reg;
            hb_reg   <= head_rd_reg;
            prev_reg <= '0;
        end
        else if (cmd.step)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= link_rd_reg;
        end
        if (cmd.load_out)
        begin
            case (cmd.out_sel)
                OUT_DUP:
                begin
                    hit_reg    <= 1'b1;
                    value_reg  <= node_rd_reg[31:0];
                    status_reg <= ST_DUP;
                end
                OUT_FULL:
                begin
                    hit_reg    <= 1'b0;
                    value_reg  <= '0;
                    status_reg <= ST_FULL;
                end
                OUT_MISS:
                begin
                    hit_reg    <= 1'b0;
                    value_reg  <= '0;
                    status_reg <= ST_MISS;
                end
                OUT_HIT:
                begin
                    hit_reg    <= 1'b1;
                    value_reg  <= node_rd_reg[31:0];
                    status_reg <= ST_OK;
                end
                default:
                begin
                    hit_reg    <= 1'b0;
                    value_reg  <= '0;
                    status_reg <= ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        sts.hash_done = h_done;
        sts.cur_end   = (cur_reg == '0) || (cur_reg > PW'(POOL_NODES));
        sts.match     = (node_rd_reg[111:32] == {tex_reg, rect_reg});
        sts.full      = (used_reg >= PW'(POOL_NODES));
        sts.clr_last  = (clr_reg == BW'(BUCKETS - 1));
        sts.action    = action_reg;
    end

    assign hit          = hit_reg;
    assign stored_value = value_reg;
    assign status       = status_reg;

endmodule

// ===== src/rkh_ctrl.sv =====
// ----------------------------------------------------------------------------
// rkh_ctrl
// Sequencer: head clear, hash, chain walk, update and result handoff.
// ----------------------------------------------------------------------------
module rkh_ctrl
    import rkh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic rsp_valid,
    input  logic rsp_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HSTART = 4'd2;
    localparam logic [3:0] S_HASH   = 4'd3;
    localparam logic [3:0] S_HREAD  = 4'd4;
    localparam logic [3:0] S_HLOAD  = 4'd5;
    localparam logic [3:0] S_WALK   = 4'd6;
    localparam logic [3:0] S_NCHK   = 4'd7;
    localparam logic [3:0] S_HASH2  = 4'd8;
    localparam logic [3:0] S_RHREAD = 4'd9;
    localparam logic [3:0] S_RELINK = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] sel_reg;
    logic [2:0] sel_next;
    logic       ovalid_reg;
    logic       ovalid_next;

    always_comb
    begin
        cmd         = '0;
        cmd.out_sel = sel_reg;
        state_next  = state_reg;
        sel_next    = sel_reg;
        ovalid_next = ovalid_reg && rsp_stall;

        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_HSTART;
                end
            end
            S_HSTART:
            begin
                if (sts.action == ACT_NONE)
                begin
                    sel_next   = OUT_OK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.hash_start = 1'b1;
                    state_next     = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.hash_done)
                    state_next = S_HREAD;
            end
            S_HREAD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_HLOAD;
            end
            S_HLOAD:
            begin
                cmd.load_cur = 1'b1;
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                if (sts.cur_end)
                begin
                    state_next = S_DONE;
                    if (sts.action == ACT_INSERT)
                    begin
                        if (sts.full)
                            sel_next = OUT_FULL;
                        else
                        begin
                            cmd.ins  = 1'b1;
                            sel_next = OUT_OK;
                        end
                    end
                    else
                        sel_next = OUT_MISS;
                end
                else
                begin
                    cmd.node_rd = 1'b1;
                    state_next  = S_NCHK;
                end
            end
            S_NCHK:
            begin
                if (!sts.match)
                begin
                    cmd.step   = 1'b1;
                    state_next = S_WALK;
                end
                else if (sts.action == ACT_REKEY)
                begin
                    cmd.unlink     = 1'b1;
                    cmd.hash_start = 1'b1;
                    cmd.hash_sel   = 1'b1;
                    state_next     = S_HASH2;
                end
                else
                begin
                    sel_next   = (sts.action == ACT_INSERT) ? OUT_DUP : OUT_HIT;
                    state_next = S_DONE;
                end
            end
            S_HASH2:
            begin
                if (sts.hash_done)
                    state_next = S_RHREAD;
            end
            S_RHREAD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = S_RELINK;
            end
            S_RELINK:
            begin
                cmd.relink = 1'b1;
                sel_next   = OUT_HIT;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || !rsp_stall)
                begin
                    cmd.load_out = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            sel_reg    <= OUT_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sel_reg    <= sel_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = ovalid_reg;

endmodule

// ===== src/rect_key_chained_hash_table.sv =====
// ----------------------------------------------------------------------------
// rect_key_chained_hash_table
// Hash map keyed by texture id and rectangle; chained buckets over a node
// pool. Insert, lookup and change key, one result word per request word.
//
//   channel  signals                 word
//   req      req_valid / req_stall   action, key, new key, entry_value
//   rsp      rsp_valid / rsp_stall   hit, stored_value, status
//
// Each word hashes its key, reads the bucket head and walks the chain; a change
// key found hashes the new key and relinks, and action 3 skips the hash. Each hash
// runs capture, reciprocal multiply, remainder and correction; each chain node is
// a node memory read and a compare. After reset a clearing pass over all BUCKETS
// bucket heads empties them; req_stall stays high meanwhile. A waiting result
// does not block the next request; it only holds the finish of the following one.
// ----------------------------------------------------------------------------
module rect_key_chained_hash_table
    import rkh_pkg::*;
#(
    parameter int BUCKETS    = 7561,
    parameter int POOL_NODES = 8192
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         action,
    input  logic [15:0]        tex_id,
    input  logic signed [15:0] x_min,
    input  logic signed [15:0] x_max,
    input  logic signed [15:0] y_min,
    input  logic signed [15:0] y_max,
    input  logic [15:0]        new_tex_id,
    input  logic signed [15:0] new_x_min,
    input  logic signed [15:0] new_x_max,
    input  logic signed [15:0] new_y_min,
    input  logic signed [15:0] new_y_max,
    input  logic [31:0]        entry_value,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic               hit,
    output logic [31:0]        stored_value,
    output logic [1:0]         status
);

    cmd_t cmd;
    sts_t sts;

    rkh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rkh_datapath #(
        .BUCKETS    (BUCKETS),
        .POOL_NODES (POOL_NODES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .action       (action),
        .tex_id       (tex_id),
        .x_min        (x_min),
        .x_max        (x_max),
        .y_min        (y_min),
        .y_max        (y_max),
        .new_tex_id   (new_tex_id),
        .new_x_min    (new_x_min),
        .new_x_max    (new_x_max),
        .new_y_min    (new_y_min),
        .new_y_max    (new_y_max),
        .entry_value  (entry_value),
        .hit          (hit),
        .stored_value (stored_value),
        .status       (status)
    );

endmodule

// ===== src/rkh_checker.sv =====
// ----------------------------------------------------------------------------
// rkh_checker
// Port-level checks on the result channel of the hash table.
// ----------------------------------------------------------------------------
module rkh_checker
    import rkh_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic        hit,
    input logic [31:0] stored_value,
    input logic [1:0]  status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result word dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(hit) && $stable(stored_value) && $stable(status))
        else $error("stalled result word changed");

    a_dup_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_DUP |-> hit)
        else $error("duplicate without hit");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !hit |-> stored_value == 32'd0)
        else $error("value on a non-hit");

    a_fail_nohit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL || status == ST_MISS) |-> !hit)
        else $error("hit with failure status");

endmodule

bind rect_key_chained_hash_table rkh_checker u_rkh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .hit          (hit),
    .stored_value (stored_value),
    .status       (status)
);

// ===== tb/rect_key_chained_hash_table_tb.sv =====
// ----------------------------------------------------------------------------
// rect_key_chained_hash_table_tb
// Self-checking bench: drives insert, lookup, change-key and no-action words
// with random gaps, predicts each result word from a software copy of the
// bucket chains and node pool, and compares every result field in order. A
// small pool and bucket count make chains long and let the pool run full.
// ----------------------------------------------------------------------------
module rect_key_chained_hash_table_tb;
    import rkh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = 61;
    localparam int NP = 256;
    localparam int RAND_WORDS = 700;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [15:0]        tex;
        logic signed [15:0] x0;
        logic signed [15:0] x1;
        logic signed [15:0] y0;
        logic signed [15:0] y1;
    } rect_key_t;

    typedef struct packed {
        logic [1:0]  act;
        rect_key_t   key;
        rect_key_t   nkey;
        logic [31:0] value;
    } req_word_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] value;
        logic [1:0]  status;
    } rsp_word_t;

    class hash_scoreboard;
        int unsigned head[];
        rect_key_t   node_key[];
        logic [31:0] node_val[];
        int unsigned node_link[];
        int unsigned used;
        rsp_word_t   pending_rsp[$];
        int          errors;
        int          words_in;
        int          words_out;
        int          status_cnt[4];

        function new();
            head = new[NB];
            node_key = new[NP];
            node_val = new[NP];
            node_link = new[NP];
            foreach (head[i]) head[i] = 0;
            used = 0;
            errors = 0;
            words_in = 0;
            words_out = 0;
        endfunction

        function int unsigned bucket_of(rect_key_t k);
            int cx;
            int cy;
            bit [31:0] h;
            cx = (int'(k.x0) + int'(k.x1)) / 2;
            cy = (int'(k.y0) + int'(k.y1)) / 2;
            h = 32'(cx) ^ 32'(cy * 97) ^ (32'(k.tex) * 32'd101);
            return h % NB;
        endfunction

        function int unsigned chain_find(int unsigned b, rect_key_t k,
                                         output int unsigned prev);
            int unsigned cur;
            int unsigned last;
            cur = head[b];
            last = 0;
            prev = 0;
            while (cur != 0) begin
                if (node_key[cur-1] == k) begin
                    prev = last;
                    return cur;
                end
                last = cur;
                cur = node_link[cur-1];
            end
            return 0;
        endfunction

        function void note_request(req_word_t w);
            rsp_word_t   r;
            int unsigned b;
            int unsigned nb;
            int unsigned n;
            int unsigned prev;
            r = '0;
            words_in++;
            if (w.act != ACT_NONE) begin
                b = bucket_of(w.key);
                n = chain_find(b, w.key, prev);
                case (w.act)
                    ACT_INSERT:
                    begin
                        if (n != 0) begin
                            r.hit = 1'b1;
                            r.value = node_val[n-1];
                            r.status = ST_DUP;
                        end
                        else if (used >= NP) begin
                            r.status = ST_FULL;
                        end
                        else begin
                            node_key[used] = w.key;
                            node_val[used] = w.value;
                            node_link[used] = head[b];
                            head[b] = used + 1;
                            used++;
                        end
                    end
                    ACT_LOOKUP:
                    begin
                        if (n != 0) begin
                            r.hit = 1'b1;
                            r.value = node_val[n-1];
                        end
                        else r.status = ST_MISS;
                    end
                    default:
                    begin
                        if (n != 0) begin
                            if (prev != 0) node_link[prev-1] = node_link[n-1];
                            else head[b] = node_link[n-1];
                            nb = bucket_of(w.nkey);
                            node_key[n-1] = w.nkey;
                            node_link[n-1] = head[nb];
                            head[nb] = n;
                            r.hit = 1'b1;
                            r.value = node_val[n-1];
                        end
                        else r.status = ST_MISS;
                    end
                endcase
            end
            pending_rsp.push_back(r);
        endfunction

        function void check_response(rsp_word_t got);
            rsp_word_t exp_rsp;
            words_out++;
            if (pending_rsp.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: hit=%0b value=%h status=%0d",
                             got.hit, got.value, got.status);
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            status_cnt[got.status]++;
            if (got !== exp_rsp) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch word %0d: exp hit=%0b value=%h status=%0d, got hit=%0b value=%h status=%0d",
                             words_out, exp_rsp.hit, exp_rsp.value, exp_rsp.status,
                             got.hit, got.value, got.status);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [1:0]         action;
    logic [15:0]        tex_id;
    logic signed [15:0] x_min;
    logic signed [15:0] x_max;
    logic signed [15:0] y_min;
    logic signed [15:0] y_max;
    logic [15:0]        new_tex_id;
    logic signed [15:0] new_x_min;
    logic signed [15:0] new_x_max;
    logic signed [15:0] new_y_min;
    logic signed [15:0] new_y_max;
    logic [31:0]        entry_value;
    logic               rsp_valid;
    logic               rsp_stall;
    logic               hit;
    logic [31:0]        stored_value;
    logic [1:0]         status;

    hash_scoreboard sb;
    rect_key_t      known_keys[$];
    int             rsp_gap;
    int             cycle_cnt;
    bit             hold_done;

    rect_key_chained_hash_table #(
        .BUCKETS    (NB),
        .POOL_NODES (NP)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .action       (action),
        .tex_id       (tex_id),
        .x_min        (x_min),
        .x_max        (x_max),
        .y_min        (y_min),
        .y_max        (y_max),
        .new_tex_id   (new_tex_id),
        .new_x_min    (new_x_min),
        .new_x_max    (new_x_max),
        .new_y_min    (new_y_min),
        .new_y_max    (new_y_max),
        .entry_value  (entry_value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .hit          (hit),
        .stored_value (stored_value),
        .status       (status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic rect_key_t rand_key();
        rect_key_t k;
        k.tex = 16'($urandom);
        k.x0 = 16'($urandom);
        k.x1 = 16'($urandom);
        k.y0 = 16'($urandom);
        k.y1 = 16'($urandom);
        if ($urandom_range(0, 9) == 0) k.x0 = 16'sh8000;
        if ($urandom_range(0, 9) == 0) k.y1 = 16'sh7fff;
        return k;
    endfunction

    function automatic rect_key_t pick_key();
        if (known_keys.size() == 0) return rand_key();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    function automatic req_word_t make_word(logic [1:0] a, rect_key_t k, rect_key_t nk);
        req_word_t w;
        w.act = a;
        w.key = k;
        w.nkey = nk;
        w.value = $urandom;
        return w;
    endfunction

    task automatic send_word(req_word_t w, int gap);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        action      <= w.act;
        tex_id      <= w.key.tex;
        x_min       <= w.key.x0;
        x_max       <= w.key.x1;
        y_min       <= w.key.y0;
        y_max       <= w.key.y1;
        new_tex_id  <= w.nkey.tex;
        new_x_min   <= w.nkey.x0;
        new_x_max   <= w.nkey.x1;
        new_y_min   <= w.nkey.y0;
        new_y_max   <= w.nkey.y1;
        entry_value <= w.value;
        req_valid   <= 1'b1;
        do @(posedge clk); while (!(req_valid && !req_stall));
        sb.note_request(w);
        if (w.act == ACT_INSERT) known_keys.push_back(w.key);
        if (w.act == ACT_REKEY) known_keys.push_back(w.nkey);
        @(negedge clk);
    endtask

    function automatic int draw_gap(int idx);
        if ((idx / 100) % 3 == 1) return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic req_word_t rand_word();
        int        sel;
        rect_key_t k;
        rect_key_t nk;
        sel = $urandom_range(0, 99);
        nk = ($urandom_range(0, 3) == 0) ? pick_key() : rand_key();
        if (sel < 45) begin
            k = ($urandom_range(0, 9) < 7) ? rand_key() : pick_key();
            return make_word(ACT_INSERT, k, nk);
        end
        k = ($urandom_range(0, 3) != 0) ? pick_key() : rand_key();
        if (sel < 75) return make_word(ACT_LOOKUP, k, nk);
        if (sel < 95) return make_word(ACT_REKEY, k, nk);
        return make_word(ACT_NONE, k, nk);
    endfunction

    initial
    begin
        rect_key_t ka;
        rect_key_t kb;
        rect_key_t kc;
        rect_key_t kn;
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        action = ACT_NONE;
        tex_id = '0;
        x_min = '0;
        x_max = '0;
        y_min = '0;
        y_max = '0;
        new_tex_id = '0;
        new_x_min = '0;
        new_x_max = '0;
        new_y_min = '0;
        new_y_max = '0;
        entry_value = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        ka = '{16'hffff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        kb = '{16'h0000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        kc = '{16'h1234, -16'sd3, 16'sd0, 16'sd5, -16'sd2};
        kn = '{16'h00ff, 16'sh8000, 16'sh7fff, -16'sd1, 16'sd0};
        send_word(make_word(ACT_LOOKUP, ka, kb), 0);
        send_word(make_word(ACT_INSERT, ka, kb), 0);
        send_word(make_word(ACT_INSERT, kb, ka), 2);
        send_word(make_word(ACT_INSERT, kc, ka), 0);
        send_word(make_word(ACT_LOOKUP, ka, kb), 1);
        send_word(make_word(ACT_LOOKUP, kb, ka), 0);
        send_word(make_word(ACT_LOOKUP, kc, ka), 0);
        send_word(make_word(ACT_INSERT, ka, kc), 0);
        send_word(make_word(ACT_LOOKUP, kn, kc), 0);
        send_word(make_word(ACT_REKEY, kn, kc), 0);
        send_word(make_word(ACT_REKEY, kc, kn), 3);
        send_word(make_word(ACT_LOOKUP, kc, kn), 0);
        send_word(make_word(ACT_LOOKUP, kn, kc), 0);
        send_word(make_word(ACT_REKEY, kn, ka), 0);
        send_word(make_word(ACT_LOOKUP, ka, kb), 0);
        send_word(make_word(ACT_REKEY, ka, ka), 0);
        send_word(make_word(ACT_LOOKUP, ka, kb), 0);
        send_word(make_word(ACT_NONE, kb, ka), 0);
        send_word(make_word(ACT_NONE, rand_key(), rand_key()), 0);

        for (int i = 0; i < RAND_WORDS; i++)
            send_word(rand_word(), draw_gap(i));

        req_valid <= 1'b0;
        while (sb.pending_rsp.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d request words, %0d results, pool use %0d of %0d",
                 sb.words_in, sb.words_out, sb.used, NP);
        $display("status counts: ok %0d dup %0d full %0d miss %0d",
                 sb.status_cnt[ST_OK], sb.status_cnt[ST_DUP],
                 sb.status_cnt[ST_FULL], sb.status_cnt[ST_MISS]);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        hold_done = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && sb != null && sb.words_in >= 350) begin
                hold_done = 1'b1;
                hold = 2000;
            end
            if (hold > 0) begin
                hold--;
                rsp_stall <= 1'b1;
            end
            else if (rsp_gap > 0) begin
                rsp_gap--;
                rsp_stall <= 1'b1;
            end
            else rsp_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n) rsp_gap <= 0;
        else if (rsp_valid && !rsp_stall) begin
            sb.check_response('{hit, stored_value, status});
            rsp_gap <= (((sb.words_out / 100) % 3) == 2) ? 0 : $urandom_range(0, 16);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial cycle_cnt = 0;

endmodule

// ===== filelist.f =====
src/rkh_pkg.sv
src/rkh_hash.sv
src/rkh_datapath.sv
src/rkh_ctrl.sv
src/rect_key_chained_hash_table.sv
src/rkh_checker.sv
tb/rect_key_chained_hash_table_tb.sv
